[rtl/iopb_pkg.sv]
// ----------------------------------------------------------------------------
// iopb_pkg
// shared types and constants of the i/o permission bitmap unit
// ----------------------------------------------------------------------------
package iopb_pkg;

   localparam int PORT_COUNT = 65536;
   localparam int MAP_BYTES  = (PORT_COUNT + 7) / 8;
   localparam int AW         = (MAP_BYTES > 1) ? $clog2(MAP_BYTES) : 1;

   localparam logic [1:0] ST_OK        = 2'd0;
   localparam logic [1:0] ST_BAD_RANGE = 2'd1;
   localparam logic [1:0] ST_BAD_FLAG  = 2'd2;
   localparam logic [1:0] ST_NO_RIGHTS = 2'd3;

   localparam logic OP_RANGE = 1'b0;
   localparam logic OP_READ  = 1'b1;

   typedef enum logic [2:0] {
      K_DONE,
      K_READ,
      K_CHECK,
      K_SET_ON,
      K_SET_OFF
   } kind_type;

   typedef struct packed {
      kind_type     kind;
      logic [1:0]   status;
      logic [AW-1:0] b0;
      logic [AW-1:0] b1;
      logic [7:0]   lmask;
      logic [7:0]   hmask;
   } cmd_type;

endpackage

[rtl/io_permission_bitmap_range_update_unit.sv]
// ----------------------------------------------------------------------------
// io_permission_bitmap_range_update_unit
// one-bit-per-port i/o permission bitmap with range update and byte read
// ----------------------------------------------------------------------------
// After reset the unit sweeps its 8192-byte bitmap to all ones, one byte per
// cycle, and takes no request from the queue until done. A request is decoded
// as it is accepted and queued; the back end walks the bitmap one byte a cycle,
// from the first to the last byte of the range, through one read port and one
// write port of the memory. A request settled by its checks alone skips the
// walk and goes straight to the result register. A waiting result holds the
// back end.
module io_permission_bitmap_range_update_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        push,
   output logic        full,
   input  logic        req_op,
   input  logic [16:0] req_first_port,
   input  logic [16:0] req_port_count,
   input  logic [7:0]  req_enable_flag,
   input  logic        req_privileged,
   input  logic [12:0] req_byte_index,
   output logic        empty,
   input  logic        pop,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_read_byte
);
   import iopb_pkg::*;

   cmd_type cmd, q_cmd;
   logic    q_empty, q_pop;

   iopb_front u_front (
      .op          (req_op),
      .first_port  (req_first_port),
      .port_count  (req_port_count),
      .enable_flag (req_enable_flag),
      .privileged  (req_privileged),
      .byte_index  (req_byte_index),
      .cmd         (cmd)
   );

   iopb_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (cmd),
      .full     (full),
      .pop      (q_pop),
      .pop_cmd  (q_cmd),
      .empty    (q_empty)
   );

   iopb_back u_back (
      .clock         (clock),
      .reset         (reset),
      .q_cmd         (q_cmd),
      .q_empty       (q_empty),
      .q_pop         (q_pop),
      .rsp_empty     (empty),
      .rsp_pop       (pop),
      .rsp_status    (rsp_status),
      .rsp_read_byte (rsp_read_byte)
   );

endmodule

[rtl/iopb_front.sv]
// ----------------------------------------------------------------------------
// iopb_front
// classifies a request into a command for the bitmap walker
// ----------------------------------------------------------------------------
module iopb_front (
   input  logic               op,
   input  logic [16:0]        first_port,
   input  logic [16:0]        port_count,
   input  logic [7:0]         enable_flag,
   input  logic               privileged,
   input  logic [12:0]        byte_index,
   output iopb_pkg::cmd_type  cmd
);
   import iopb_pkg::*;

   logic [17:0] sum;
   logic [16:0] last;

   always_comb begin
      sum  = {1'b0, first_port} + {1'b0, port_count};
      last = 17'(sum - 18'd1);
      cmd.kind   = K_DONE;
      cmd.status = ST_OK;
      cmd.b0     = AW'(first_port >> 3);
      cmd.b1     = AW'(last >> 3);
      cmd.lmask  = 8'hff << first_port[2:0];
      cmd.hmask  = 8'hff >> (3'd7 - last[2:0]);
      if (op == OP_READ) begin
         cmd.b0 = AW'(byte_index);
         cmd.b1 = AW'(byte_index);
         if ({1'b0, byte_index} < 14'(MAP_BYTES)) begin
            cmd.kind = K_READ;
         end else begin
            cmd.status = ST_BAD_RANGE;
         end
      end else if (port_count == 17'd0) begin
         cmd.status = ST_OK;
      end else if (sum > 18'(PORT_COUNT)) begin
         cmd.status = ST_BAD_RANGE;
      end else if (enable_flag > 8'd1) begin
         cmd.status = ST_BAD_FLAG;
      end else if (enable_flag == 8'd1 && !privileged) begin
         cmd.kind = K_CHECK;
      end else if (enable_flag == 8'd1) begin
         cmd.kind = K_SET_ON;
      end else begin
         cmd.kind = K_SET_OFF;
      end
   end

endmodule

[rtl/iopb_queue.sv]
// ----------------------------------------------------------------------------
// iopb_queue
// two-entry command queue between front and back
// ----------------------------------------------------------------------------
module iopb_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push,
   input  iopb_pkg::cmd_type push_cmd,
   output logic              full,
   input  logic              pop,
   output iopb_pkg::cmd_type pop_cmd,
   output logic              empty
);
   import iopb_pkg::*;

   cmd_type    mem_ff [2];
   logic       wp_ff, wp_in, rp_ff, rp_in;
   logic [1:0] cnt_ff, cnt_in;
   logic       do_push, do_pop;

   assign full    = (cnt_ff == 2'd2);
   assign empty   = (cnt_ff == 2'd0);
   assign pop_cmd = mem_ff[rp_ff];
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;

   always_comb begin
      wp_in  = do_push ? !wp_ff : wp_ff;
      rp_in  = do_pop ? !rp_ff : rp_ff;
      cnt_in = cnt_ff + 2'(do_push) - 2'(do_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= 1'b0;
         rp_ff  <= 1'b0;
         cnt_ff <= 2'd0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
      if (do_push) begin
         mem_ff[wp_ff] <= push_cmd;
      end
   end

endmodule

[rtl/iopb_back.sv]
// ----------------------------------------------------------------------------
// iopb_back
// bitmap memory, byte walker and result register
// ----------------------------------------------------------------------------
module iopb_back (
   input  logic              clock,
   input  logic              reset,
   input  iopb_pkg::cmd_type q_cmd,
   input  logic              q_empty,
   output logic              q_pop,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output logic [1:0]        rsp_status,
   output logic [7:0]        rsp_read_byte
);
   import iopb_pkg::*;

   typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_RUN} state_type;

   logic [7:0]    mem [MAP_BYTES];
   logic [7:0]    rdata_ff;
   state_type     state_ff, state_in;
   cmd_type       cmd_ff, cmd_in;
   logic [AW-1:0] addr_ff, addr_in, vaddr_ff, vaddr_in;
   logic          issue_ff, issue_in, v_ff, v_in, bad_ff, bad_in;
   logic          ov_ff, ov_in;
   logic [1:0]    st_ff, st_in;
   logic [7:0]    rb_ff, rb_in;
   logic          we;
   logic [AW-1:0] wa;
   logic [7:0]    wd, mask;

   assign rsp_empty     = !ov_ff;
   assign rsp_status    = st_ff;
   assign rsp_read_byte = rb_ff;
   assign q_pop         = (state_ff == S_IDLE) && !ov_ff && !q_empty;

   always_comb begin
      state_in = state_ff;
      cmd_in   = cmd_ff;
      addr_in  = addr_ff;
      vaddr_in = vaddr_ff;
      issue_in = issue_ff;
      v_in     = 1'b0;
      bad_in   = bad_ff;
      ov_in    = ov_ff && !rsp_pop;
      st_in    = st_ff;
      rb_in    = rb_ff;
      we       = 1'b0;
      wa       = vaddr_ff;
      mask     = ((vaddr_ff == cmd_ff.b0) ? cmd_ff.lmask : 8'hff)
               & ((vaddr_ff == cmd_ff.b1) ? cmd_ff.hmask : 8'hff);
      wd       = (cmd_ff.kind == K_SET_ON) ? (rdata_ff & ~mask) : (rdata_ff | mask);
      case (state_ff)
         S_CLEAR: begin
            we = 1'b1;
            wa = addr_ff;
            wd = 8'hff;
            addr_in = addr_ff + AW'(1);
            if (addr_ff == AW'(MAP_BYTES - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (q_pop) begin
               cmd_in = q_cmd;
               if (q_cmd.kind == K_DONE) begin
                  ov_in = 1'b1;
                  st_in = q_cmd.status;
                  rb_in = 8'h00;
               end else begin
                  state_in = S_RUN;
                  addr_in  = q_cmd.b0;
                  issue_in = 1'b1;
                  bad_in   = 1'b0;
               end
            end
         end
         S_RUN: begin
            if (issue_ff) begin
               v_in     = 1'b1;
               vaddr_in = addr_ff;
               addr_in  = addr_ff + AW'(1);
               issue_in = (addr_ff != cmd_ff.b1);
            end
            if (v_ff) begin
               case (cmd_ff.kind)
                  K_SET_ON, K_SET_OFF: we = 1'b1;
                  K_CHECK: bad_in = bad_ff || ((rdata_ff & mask) != 8'h00);
                  default: we = 1'b0;
               endcase
               if (vaddr_ff == cmd_ff.b1) begin
                  state_in = S_IDLE;
                  ov_in    = 1'b1;
                  rb_in    = (cmd_ff.kind == K_READ) ? rdata_ff : 8'h00;
                  st_in    = (cmd_ff.kind == K_CHECK &&
                              (bad_ff || ((rdata_ff & mask) != 8'h00)))
                             ? ST_NO_RIGHTS : ST_OK;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      rdata_ff <= mem[addr_ff];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         addr_ff  <= '0;
         issue_ff <= 1'b0;
         v_ff     <= 1'b0;
         ov_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         addr_ff  <= addr_in;
         issue_ff <= issue_in;
         v_ff     <= v_in;
         ov_ff    <= ov_in;
      end
      cmd_ff   <= cmd_in;
      vaddr_ff <= vaddr_in;
      bad_ff   <= bad_in;
      st_ff    <= st_in;
      rb_ff    <= rb_in;
   end

endmodule

[test/io_permission_bitmap_range_update_unit_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// io_permission_bitmap_range_update_unit_tb
// self-checking bench for the i/o permission bitmap range update unit: a
// directed table then random range and read beats, each result checked
// against a bit-level bitmap model kept in the bench
// ----------------------------------------------------------------------------
module io_permission_bitmap_range_update_unit_tb;
   import iopb_pkg::*;

   localparam int LIMIT = 6000000;

   typedef struct {
      logic        op;
      logic [16:0] first_port;
      logic [16:0] port_count;
      logic [7:0]  enable_flag;
      logic        privileged;
      logic [12:0] byte_index;
      logic        known;
      logic [1:0]  status;
      logic [7:0]  read_byte;
   } beat_type;

   typedef struct {
      logic [1:0] status;
      logic [7:0] read_byte;
   } rsp_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        push = 1'b0;
   logic        full;
   logic        req_op = 1'b0;
   logic [16:0] req_first_port = '0;
   logic [16:0] req_port_count = '0;
   logic [7:0]  req_enable_flag = '0;
   logic        req_privileged = 1'b0;
   logic [12:0] req_byte_index = '0;
   logic        empty;
   logic        pop = 1'b0;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_read_byte;

   logic [PORT_COUNT-1:0] port_denied;
   rsp_type  expected_rsp[$];
   beat_type directed[$];
   int    errors = 0;
   int    cycles = 0;
   bit    stim_done = 1'b0;
   bit    calm = 1'b0;
   bit    hold_pop = 1'b0;

   io_permission_bitmap_range_update_unit uut (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("[io_permission_bitmap_range_update_unit] ERROR");
         $finish;
      end
   end

   function automatic rsp_type predict_permission(beat_type b);
      rsp_type r;
      int   lo;
      int   hi;
      r.status = ST_OK;
      r.read_byte = 8'h00;
      lo = b.first_port;
      hi = lo + b.port_count - 1;
      if (b.op == OP_READ) begin
         r.read_byte = port_denied[b.byte_index*8 +: 8];
      end else if (b.port_count == 0) begin
         r.status = ST_OK;
      end else if (lo + b.port_count > PORT_COUNT) begin
         r.status = ST_BAD_RANGE;
      end else if (b.enable_flag > 1) begin
         r.status = ST_BAD_FLAG;
      end else if (b.enable_flag == 1 && !b.privileged) begin
         for (int p = lo; p <= hi; p++)
            if (port_denied[p]) r.status = ST_NO_RIGHTS;
      end else begin
         for (int p = lo; p <= hi; p++) port_denied[p] = (b.enable_flag == 0);
      end
      return r;
   endfunction

   function automatic beat_type mk(logic op, int first, int count, int flag, logic priv,
                                   int idx, logic known = 0, int st = 0, int rd = 0);
      beat_type b;
      b.op = op; b.first_port = first; b.port_count = count;
      b.enable_flag = flag; b.privileged = priv; b.byte_index = idx;
      b.known = known; b.status = st; b.read_byte = rd;
      return b;
   endfunction

   function automatic beat_type random_beat();
      beat_type b;
      int    sel;
      b = mk(1'b0, 0, 0, 0, 1'b0, $urandom_range(0, 8191));
      sel = $urandom_range(0, 99);
      b.privileged = $urandom_range(0, 3) != 0;
      b.enable_flag = $urandom_range(0, 1);
      if ($urandom_range(0, 15) == 0) b.enable_flag = $urandom_range(0, 255);
      b.first_port = $urandom_range(0, 65535);
      if (sel < 70) b.port_count = $urandom_range(1, 40);
      else if (sel < 78) b.port_count = $urandom_range(1, 2000);
      else if (sel < 85) b.port_count = $urandom_range(0, 131071);
      else begin
         b.op = OP_READ;
         b.first_port = $urandom_range(0, 131071);
         b.port_count = $urandom_range(0, 131071);
      end
      if ($urandom_range(0, 9) == 0) b.first_port = $urandom_range(65530, 131071);
      if (b.op == OP_RANGE && b.port_count != 0 && $urandom_range(0, 1) == 0) begin
         if (b.first_port + b.port_count > PORT_COUNT && b.port_count <= 2000)
            b.first_port = PORT_COUNT - b.port_count - $urandom_range(0, 16);
      end
      return b;
   endfunction

   task automatic send_beat(beat_type b);
      rsp_type r;
      if (!calm && $urandom_range(0, 3) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_op <= b.op;
      req_first_port <= b.first_port;
      req_port_count <= b.port_count;
      req_enable_flag <= b.enable_flag;
      req_privileged <= b.privileged;
      req_byte_index <= b.byte_index;
      push <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      r = predict_permission(b);
      if (b.known && (r.status !== b.status || r.read_byte !== b.read_byte)) begin
         $error("table row disagrees with model: status %0d/%0d byte %h/%h",
                b.status, r.status, b.read_byte, r.read_byte);
         errors++;
      end
      if (b.known) begin
         r.status = b.status;
         r.read_byte = b.read_byte;
      end
      expected_rsp.push_back(r);
      @(negedge clock);
   endtask

   // result side: random pop bursts, a long hold-off once
   initial begin
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (hold_pop) begin
            pop <= 1'b0;
            repeat (400) @(negedge clock);
            hold_pop = 1'b0;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            pop <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clock);
         end else begin
            pop <= 1'b1;
            @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && pop && !empty) begin
         if (expected_rsp.size() == 0) begin
            $error("unexpected beat: status %0d byte %h", rsp_status, rsp_read_byte);
            errors++;
         end else begin
            rsp_type e;
            e = expected_rsp.pop_front();
            if (rsp_status !== e.status) begin
               $error("status expected %0d actual %0d", e.status, rsp_status);
               errors++;
            end
            if (rsp_read_byte !== e.read_byte) begin
               $error("read_byte expected %h actual %h", e.read_byte, rsp_read_byte);
               errors++;
            end
         end
      end
   end

   initial begin
      port_denied = '1;
      directed.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 1, ST_OK, 8'hff));
      directed.push_back(mk(OP_READ, 131071, 131071, 255, 1, 8191, 1, ST_OK, 8'hff));
      directed.push_back(mk(OP_RANGE, 131071, 0, 255, 0, 0, 1, ST_OK, 0));
      directed.push_back(mk(OP_RANGE, 65535, 2, 1, 1, 0, 1, ST_BAD_RANGE, 0));
      directed.push_back(mk(OP_RANGE, 131071, 131071, 1, 1, 0, 1, ST_BAD_RANGE, 0));
      directed.push_back(mk(OP_RANGE, 0, 1, 2, 1, 0, 1, ST_BAD_FLAG, 0));
      directed.push_back(mk(OP_RANGE, 0, 1, 255, 0, 0, 1, ST_BAD_FLAG, 0));
      directed.push_back(mk(OP_RANGE, 3, 4, 1, 0, 0, 1, ST_NO_RIGHTS, 0));
      directed.push_back(mk(OP_RANGE, 3, 10, 1, 1, 0));
      directed.push_back(mk(OP_READ, 0, 0, 0, 0, 0, 1, ST_OK, 8'h07));
      directed.push_back(mk(OP_READ, 0, 0, 0, 0, 1, 1, ST_OK, 8'he0));
      directed.push_back(mk(OP_RANGE, 4, 5, 1, 0, 0, 1, ST_OK, 0));
      directed.push_back(mk(OP_RANGE, 4, 10, 1, 0, 0, 1, ST_NO_RIGHTS, 0));
      directed.push_back(mk(OP_RANGE, 5, 2, 0, 0, 0));
      directed.push_back(mk(OP_READ, 0, 0, 0, 0, 0));
      directed.push_back(mk(OP_RANGE, 0, 65536, 1, 1, 0, 1, ST_OK, 0));
      directed.push_back(mk(OP_READ, 0, 0, 0, 0, 8191, 1, ST_OK, 8'h00));
      directed.push_back(mk(OP_RANGE, 65535, 1, 0, 1, 0, 1, ST_OK, 0));
      directed.push_back(mk(OP_READ, 0, 0, 0, 0, 8191, 1, ST_OK, 8'h80));
      directed.push_back(mk(OP_RANGE, 65528, 8, 1, 0, 0, 1, ST_NO_RIGHTS, 0));
      directed.push_back(mk(OP_RANGE, 0, 65536, 0, 0, 0, 1, ST_OK, 0));
      directed.push_back(mk(OP_READ, 0, 0, 0, 0, 4096, 1, ST_OK, 8'hff));
      directed.push_back(mk(OP_RANGE, 8, 65528, 1, 1, 0));
      directed.push_back(mk(OP_RANGE, 16, 16, 0, 1, 0));

      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      foreach (directed[i]) send_beat(directed[i]);
      hold_pop = 1'b1;
      for (int i = 0; i < 76; i++) begin
         if (i == 60) calm = 1'b1;
         send_beat(random_beat());
      end
      push <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (errors == 0) begin
         $display("[io_permission_bitmap_range_update_unit] OK");
      end else begin
         $display("[io_permission_bitmap_range_update_unit] ERROR");
      end
      $finish;
   end
endmodule
